// ===== hdl/pool_block_allocator_heap_defines.svh =====
// Assertion macros shared by the pool block allocator RTL.
`ifndef POOL_BLOCK_ALLOCATOR_HEAP_DEFINES_SVH
`define POOL_BLOCK_ALLOCATOR_HEAP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PBA_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PBA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pba_pkg.sv =====
// Package with widths, slot type, state and command types of the pool block allocator.
`default_nettype none

package pba_pkg;

    localparam int MAX_BLOCKS      = 64;
    localparam int BLOCK_GRANULE   = 4096;
    localparam int FIRST_BLOCK_MIN = 256;
    localparam int SIZE_BITS       = 24;
    localparam int ALIGN_BITS      = 13;
    localparam int CAP_BITS        = SIZE_BITS + 1;
    localparam int SLOT_BITS       = $clog2(MAX_BLOCKS);
    localparam int COUNT_BITS      = $clog2(MAX_BLOCKS + 1);
    localparam int ID_BITS         = 6;

    typedef struct packed {
        logic [CAP_BITS-1:0]  remaining;
        logic [CAP_BITS-1:0]  capacity;
        logic [SLOT_BITS-1:0] ident;
    } slot_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_ROOT_EV,
        ST_SD_RD,
        ST_SD_EV,
        ST_ROOT2_RD,
        ST_ROOT2_EV,
        ST_SU_RD,
        ST_SU_EV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic make_first;
        logic rd_root;
        logic try_root;
        logic sd_begin;
        logic rd_kids;
        logic sd_eval;
        logic place;
        logic full_res;
        logic make_new;
        logic rd_up;
        logic su_eval;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic root_fit;
        logic table_full;
        logic has_kid;
        logic sd_move;
        logic node_high;
        logic su_move;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/pba_ctrl.sv =====
// Controller state machine that sequences the root tries and heap sifts.
`default_nettype none

module pba_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire pba_pkg::status_t sts,
    output pba_pkg::cmd_t         cmd
);
    import pba_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (sts.count_zero)
                begin
                    cmd.make_first = 1'b1;
                    state_next     = ST_DONE;
                end
                else
                begin
                    cmd.rd_root = 1'b1;
                    state_next  = ST_ROOT_EV;
                end
            end
            ST_ROOT_EV:
            begin
                cmd.try_root = 1'b1;
                if (sts.root_fit)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.sd_begin = 1'b1;
                    state_next   = ST_SD_RD;
                end
            end
            ST_SD_RD:
            begin
                if (sts.has_kid)
                begin
                    cmd.rd_kids = 1'b1;
                    state_next  = ST_SD_EV;
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = ST_ROOT2_RD;
                end
            end
            ST_SD_EV:
            begin
                cmd.sd_eval = 1'b1;
                state_next  = sts.sd_move ? ST_SD_RD : ST_ROOT2_RD;
            end
            ST_ROOT2_RD:
            begin
                cmd.rd_root = 1'b1;
                state_next  = ST_ROOT2_EV;
            end
            ST_ROOT2_EV:
            begin
                cmd.try_root = 1'b1;
                priority if (sts.root_fit)
                begin
                    state_next = ST_DONE;
                end
                else if (sts.table_full)
                begin
                    cmd.full_res = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cmd.make_new = 1'b1;
                    state_next   = ST_SU_RD;
                end
            end
            ST_SU_RD:
            begin
                if (sts.node_high)
                begin
                    cmd.rd_up  = 1'b1;
                    state_next = ST_SU_EV;
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_SU_EV:
            begin
                cmd.su_eval = 1'b1;
                state_next  = sts.su_move ? ST_SU_RD : ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/pba_datapath.sv =====
// Datapath with the slot memory, fit check, sift registers and result register.
`default_nettype none

module pba_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire pba_pkg::cmd_t                   cmd,
    output pba_pkg::status_t                     sts,
    input  wire logic [pba_pkg::SIZE_BITS-1:0]   request_size,
    input  wire logic [pba_pkg::ALIGN_BITS-1:0]  alignment,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_ready,
    output logic [pba_pkg::ID_BITS-1:0]          block_id,
    output logic [pba_pkg::CAP_BITS-1:0]         byte_offset,
    output logic                                 made_new_block,
    output logic [pba_pkg::CAP_BITS-1:0]         new_block_bytes,
    output logic                                 pool_full
);
    import pba_pkg::*;

    localparam logic [CAP_BITS-1:0] GRAN_MASK = CAP_BITS'(BLOCK_GRANULE - 1);
    localparam logic [CAP_BITS-1:0] FIRST_MIN = CAP_BITS'(FIRST_BLOCK_MIN);
    localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(MAX_BLOCKS);

    // Slot memory: one write port, two registered read ports.
    slot_t mem [MAX_BLOCKS];
    slot_t rd_a_reg;
    slot_t rd_b_reg;
    logic [SLOT_BITS-1:0] raddr_a;
    logic [SLOT_BITS-1:0] raddr_b;
    logic [SLOT_BITS-1:0] waddr;
    slot_t wdata;
    logic we;

    logic [COUNT_BITS-1:0] count_reg;
    logic [SLOT_BITS-1:0]  node_reg;
    slot_t                 carry_reg;
    logic [SIZE_BITS-1:0]  size_reg;
    logic [ALIGN_BITS-1:0] amask_reg;

    logic [ID_BITS-1:0]  res_id_reg;
    logic [CAP_BITS-1:0] res_off_reg;
    logic                res_made_reg;
    logic [CAP_BITS-1:0] res_bytes_reg;
    logic                res_full_reg;
    logic                out_valid_reg;

    // Fit check on the registered root word.
    logic [CAP_BITS-1:0] used;
    logic [CAP_BITS:0]   off_sum;
    logic [CAP_BITS:0]   off_al;
    logic                fit;
    logic [CAP_BITS-1:0] root_rem_new;

    // New block sizing.
    logic [CAP_BITS-1:0] round_sum;
    logic [CAP_BITS-1:0] rounded;
    logic [CAP_BITS-1:0] first_cap;

    // Heap navigation.
    logic [COUNT_BITS-1:0] kid_l;
    logic                  right_ok;
    logic [SLOT_BITS-1:0]  left_idx;
    logic [SLOT_BITS-1:0]  right_idx;
    logic                  use_right;
    slot_t                 kid_ent;
    logic [SLOT_BITS-1:0]  kid_idx;
    logic [SLOT_BITS-1:0]  up_idx;
    logic                  sd_move;
    logic                  su_move;

    always_comb
    begin
        used    = (rd_a_reg.remaining <= rd_a_reg.capacity)
                  ? rd_a_reg.capacity - rd_a_reg.remaining : rd_a_reg.capacity;
        off_sum = {1'b0, used} + (CAP_BITS+1)'(amask_reg);
        off_al  = off_sum & ~((CAP_BITS+1)'(amask_reg));
        fit     = (off_al <= {1'b0, rd_a_reg.capacity}) &&
                  (({1'b0, rd_a_reg.capacity} - off_al) >= (CAP_BITS+1)'(size_reg));
        root_rem_new = rd_a_reg.capacity - off_al[CAP_BITS-1:0] - CAP_BITS'(size_reg);

        round_sum = CAP_BITS'(size_reg) + GRAN_MASK;
        rounded   = round_sum & ~GRAN_MASK;
        first_cap = (CAP_BITS'(size_reg) < FIRST_MIN) ? FIRST_MIN : rounded;

        kid_l     = {node_reg, 1'b1};
        right_ok  = ({1'b0, kid_l} + (COUNT_BITS+1)'(1)) < {1'b0, count_reg};
        left_idx  = kid_l[SLOT_BITS-1:0];
        right_idx = left_idx + SLOT_BITS'(1);
        use_right = right_ok && (rd_b_reg.remaining > rd_a_reg.remaining);
        kid_ent   = use_right ? rd_b_reg : rd_a_reg;
        kid_idx   = use_right ? right_idx : left_idx;
        sd_move   = kid_ent.remaining > carry_reg.remaining;
        up_idx    = (node_reg - SLOT_BITS'(1)) >> 1;
        su_move   = rd_a_reg.remaining < carry_reg.remaining;
    end

    always_comb
    begin
        sts.count_zero = (count_reg == '0);
        sts.root_fit   = fit;
        sts.table_full = (count_reg == FULL_COUNT);
        sts.has_kid    = kid_l < count_reg;
        sts.sd_move    = sd_move;
        sts.node_high  = node_reg >= SLOT_BITS'(3);
        sts.su_move    = su_move;
        sts.out_free   = !out_valid_reg || rsp_ready;
    end

    // Read and write address selection.
    always_comb
    begin
        raddr_a = '0;
        raddr_b = '0;
        if (cmd.rd_kids)
        begin
            raddr_a = left_idx;
            raddr_b = right_idx;
        end
        else if (cmd.rd_up)
        begin
            raddr_a = up_idx;
        end

        we    = 1'b0;
        waddr = node_reg;
        wdata = carry_reg;
        priority if (cmd.make_first)
        begin
            we    = 1'b1;
            waddr = '0;
            wdata = '{remaining: first_cap - CAP_BITS'(size_reg),
                      capacity: first_cap, ident: '0};
        end
        else if (cmd.try_root && fit)
        begin
            we    = 1'b1;
            waddr = '0;
            wdata = '{remaining: root_rem_new, capacity: rd_a_reg.capacity,
                      ident: rd_a_reg.ident};
        end
        else if (cmd.sd_eval)
        begin
            we    = 1'b1;
            wdata = sd_move ? kid_ent : carry_reg;
        end
        else if (cmd.su_eval)
        begin
            we    = 1'b1;
            wdata = su_move ? rd_a_reg : carry_reg;
        end
        else if (cmd.place)
        begin
            we = 1'b1;
        end
        else
        begin
            we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.make_first)
            begin
                count_reg <= COUNT_BITS'(1);
            end
            else if (cmd.make_new)
            begin
                count_reg <= count_reg + COUNT_BITS'(1);
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers and result word.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            size_reg  <= request_size;
            amask_reg <= (alignment != '0) ? alignment - ALIGN_BITS'(1) : '0;
        end
        if (cmd.sd_begin)
        begin
            carry_reg <= rd_a_reg;
            node_reg  <= '0;
        end
        else if (cmd.sd_eval && sd_move)
        begin
            node_reg <= kid_idx;
        end
        else if (cmd.su_eval && su_move)
        begin
            node_reg <= up_idx;
        end
        else if (cmd.make_new)
        begin
            node_reg  <= count_reg[SLOT_BITS-1:0];
            carry_reg <= '{remaining: rounded - CAP_BITS'(size_reg),
                           capacity: rounded, ident: count_reg[SLOT_BITS-1:0]};
        end

        priority if (cmd.make_first)
        begin
            res_id_reg    <= '0;
            res_off_reg   <= '0;
            res_made_reg  <= 1'b1;
            res_bytes_reg <= first_cap;
            res_full_reg  <= 1'b0;
        end
        else if (cmd.try_root && fit)
        begin
            res_id_reg    <= ID_BITS'(rd_a_reg.ident);
            res_off_reg   <= off_al[CAP_BITS-1:0];
            res_made_reg  <= 1'b0;
            res_bytes_reg <= '0;
            res_full_reg  <= 1'b0;
        end
        else if (cmd.full_res)
        begin
            res_id_reg    <= '0;
            res_off_reg   <= '0;
            res_made_reg  <= 1'b0;
            res_bytes_reg <= '0;
            res_full_reg  <= 1'b1;
        end
        else if (cmd.make_new)
        begin
            res_id_reg    <= ID_BITS'(count_reg[SLOT_BITS-1:0]);
            res_off_reg   <= '0;
            res_made_reg  <= 1'b1;
            res_bytes_reg <= rounded;
            res_full_reg  <= 1'b0;
        end
        else
        begin
            res_id_reg <= res_id_reg;
        end

        if (cmd.publish)
        begin
            block_id        <= res_id_reg;
            byte_offset     <= res_off_reg;
            made_new_block  <= res_made_reg;
            new_block_bytes <= res_bytes_reg;
            pool_full       <= res_full_reg;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hdl/pool_block_allocator_heap.sv =====
// Top level of the pool block allocator: controller, datapath and checks.
//
// Usage: one request word (request_size, alignment) enters on req_valid/req_ready,
// and exactly one result word (block_id, byte_offset, made_new_block,
// new_block_bytes, pool_full) leaves on rsp_valid/rsp_ready.
// Blocks live in a 64-slot max-heap on remaining bytes held in a two-read,
// one-write memory with registered read data; each heap access takes a read
// state and an evaluate state, and that memory port pair sets the timing.
// Steps after acceptance: the very first block is written at once; else the root
// is read and tried. A miss sifts the root down (read and evaluate per level, only
// a place for a final level with no child), reads and tries the root again and,
// unless the table is full, adds a block and sifts it up (read and evaluate per
// level, then a place at slot 1 or 2). The block is ready for a new request in
// the cycle after the result is handed to the output register.
// The output register holds a finished word while the receiver stalls, so the
// next request is accepted and worked on meanwhile; it only waits at its end
// if the previous word is still not taken.
// Reset clears the block count and the output valid; slot contents need no
// clearing because only slots below the count are ever used.
`default_nettype none
`include "pool_block_allocator_heap_defines.svh"

module pool_block_allocator_heap (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_ready,
    input  wire logic [pba_pkg::SIZE_BITS-1:0]   request_size,
    input  wire logic [pba_pkg::ALIGN_BITS-1:0]  alignment,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_ready,
    output logic [pba_pkg::ID_BITS-1:0]          block_id,
    output logic [pba_pkg::CAP_BITS-1:0]         byte_offset,
    output logic                                 made_new_block,
    output logic [pba_pkg::CAP_BITS-1:0]         new_block_bytes,
    output logic                                 pool_full
);
    import pba_pkg::*;

    cmd_t    cmd;
    status_t sts;

    pba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pba_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .request_size    (request_size),
        .alignment       (alignment),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .block_id        (block_id),
        .byte_offset     (byte_offset),
        .made_new_block  (made_new_block),
        .new_block_bytes (new_block_bytes),
        .pool_full       (pool_full)
    );

    // A pool-full word is only produced while the table really is full.
    `PBA_ASSERT_NOW(a_full_means_table_full, rsp_valid && pool_full, sts.table_full, "pool_full without full table")
    // A reused block never reports a fresh block size.
    `PBA_ASSERT_NOW(a_bytes_only_new, rsp_valid && !made_new_block, new_block_bytes == '0, "new_block_bytes set without new block")
    // Only one request is in work at a time.
    `PBA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "request accepted while busy")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the pool block allocator with a heap of blocks.
`default_nettype none

module tb;
    import pba_pkg::*;

    localparam int RANDOM_WORDS   = 1500;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AT_WORD   = 500;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        logic [SIZE_BITS-1:0]  size;
        logic [ALIGN_BITS-1:0] align;
    } alloc_req_t;

    typedef struct packed {
        logic [ID_BITS-1:0]  block_id;
        logic [CAP_BITS-1:0] byte_offset;
        logic                made_new;
        logic [CAP_BITS-1:0] new_bytes;
        logic                pool_full;
    } alloc_word_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  req_valid    = 1'b0;
    logic                  req_ready;
    logic [SIZE_BITS-1:0]  request_size = '0;
    logic [ALIGN_BITS-1:0] alignment    = '0;
    logic                  rsp_valid;
    logic                  rsp_ready    = 1'b0;
    logic [ID_BITS-1:0]    block_id;
    logic [CAP_BITS-1:0]   byte_offset;
    logic                  made_new_block;
    logic [CAP_BITS-1:0]   new_block_bytes;
    logic                  pool_full;

    pool_block_allocator_heap uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .request_size    (request_size),
        .alignment       (alignment),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .block_id        (block_id),
        .byte_offset     (byte_offset),
        .made_new_block  (made_new_block),
        .new_block_bytes (new_block_bytes),
        .pool_full       (pool_full)
    );

    always #6 clk = ~clk;

    // Predicted heap of blocks, ordered on free bytes.
    logic [CAP_BITS-1:0]  heap_free [MAX_BLOCKS];
    logic [CAP_BITS-1:0]  heap_cap  [MAX_BLOCKS];
    logic [SLOT_BITS-1:0] heap_id   [MAX_BLOCKS];
    int                   heap_count = 0;

    alloc_req_t  pending_reqs [$];
    alloc_word_t result_expect [$];

    int error_count = 0;
    int words_sent  = 0;
    int words_seen  = 0;
    int fit_count   = 0;
    int new_count   = 0;
    int full_count  = 0;

    function automatic void heap_swap(int a, int b);
        logic [CAP_BITS-1:0]  f;
        logic [CAP_BITS-1:0]  c;
        logic [SLOT_BITS-1:0] d;
        f = heap_free[a];
        c = heap_cap[a];
        d = heap_id[a];
        heap_free[a] = heap_free[b];
        heap_cap[a]  = heap_cap[b];
        heap_id[a]   = heap_id[b];
        heap_free[b] = f;
        heap_cap[b]  = c;
        heap_id[b]   = d;
    endfunction

    function automatic void sink_root();
        int node;
        int kid;
        node = 0;
        while (2 * node + 1 < heap_count) begin
            kid = 2 * node + 1;
            if (kid + 1 < heap_count && heap_free[kid + 1] > heap_free[kid])
                kid++;
            if (heap_free[kid] <= heap_free[node])
                return;
            heap_swap(node, kid);
            node = kid;
        end
    endfunction

    // The climb stops at slot 1 or 2 and never displaces the root.
    function automatic void float_up(int start);
        int node;
        int up;
        node = start;
        while (node >= 3) begin
            up = (node - 1) >> 1;
            if (heap_free[up] >= heap_free[node])
                return;
            heap_swap(node, up);
            node = up;
        end
    endfunction

    function automatic bit fit_in_root(longint unsigned sz, longint unsigned amask,
                                       output longint unsigned off);
        longint unsigned cap;
        longint unsigned rem;
        longint unsigned used;
        longint unsigned o;
        cap  = heap_cap[0];
        rem  = heap_free[0];
        used = (rem <= cap) ? cap - rem : cap;
        o    = (used + amask) & ~amask;
        off  = 0;
        if (o > cap || cap - o < sz)
            return 1'b0;
        heap_free[0] = CAP_BITS'(cap - o - sz);
        off = o;
        return 1'b1;
    endfunction

    function automatic alloc_word_t place_request(logic [SIZE_BITS-1:0] size_in,
                                                  logic [ALIGN_BITS-1:0] align_in);
        alloc_word_t     w;
        longint unsigned sz;
        longint unsigned amask;
        longint unsigned off;
        longint unsigned cap;
        longint unsigned gran;
        int              slot;
        w     = '0;
        sz    = size_in;
        gran  = BLOCK_GRANULE;
        amask = (align_in != 0) ? longint'(align_in) - 1 : 0;
        if (heap_count == 0) begin
            cap = (sz < FIRST_BLOCK_MIN) ? FIRST_BLOCK_MIN : ((sz + gran - 1) / gran) * gran;
            heap_cap[0]  = CAP_BITS'(cap);
            heap_free[0] = CAP_BITS'(cap - sz);
            heap_id[0]   = '0;
            heap_count   = 1;
            w.made_new   = 1'b1;
            w.new_bytes  = CAP_BITS'(cap);
            return w;
        end
        if (fit_in_root(sz, amask, off)) begin
            w.block_id    = heap_id[0];
            w.byte_offset = CAP_BITS'(off);
            return w;
        end
        sink_root();
        if (fit_in_root(sz, amask, off)) begin
            w.block_id    = heap_id[0];
            w.byte_offset = CAP_BITS'(off);
            return w;
        end
        if (heap_count >= MAX_BLOCKS) begin
            w.pool_full = 1'b1;
            return w;
        end
        slot = heap_count;
        cap  = ((sz + gran - 1) / gran) * gran;
        heap_cap[slot]  = CAP_BITS'(cap);
        heap_free[slot] = CAP_BITS'(cap - sz);
        heap_id[slot]   = SLOT_BITS'(slot);
        heap_count      = slot + 1;
        w.block_id      = ID_BITS'(slot);
        w.made_new      = 1'b1;
        w.new_bytes     = CAP_BITS'(cap);
        float_up(slot);
        return w;
    endfunction

    // Sender: gaps are drawn per word, with two stretches sent back to back.
    int send_wait = 0;

    always @(posedge clk or negedge rst_n) begin : sender
        alloc_req_t next_req;
        if (!rst_n) begin
            req_valid    <= 1'b0;
            request_size <= '0;
            alignment    <= '0;
            send_wait    <= 0;
        end
        else begin
            if (req_valid && req_ready) begin
                result_expect.push_back(place_request(request_size, alignment));
                words_sent++;
            end
            if (!req_valid || req_ready) begin
                if (send_wait > 0) begin
                    send_wait <= send_wait - 1;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0) begin
                    next_req     = pending_reqs.pop_front();
                    req_valid    <= 1'b1;
                    request_size <= next_req.size;
                    alignment    <= next_req.align;
                    if ((words_sent >= 300 && words_sent < 450) ||
                        (words_sent >= 900 && words_sent < 1000))
                        send_wait <= 0;
                    else
                        send_wait <= $urandom_range(0, 8);
                end
                else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: a stall is drawn after each word; once it holds off long enough
    // for the block to fill and push back on the request side.
    int rx_wait = 0;

    always @(posedge clk or negedge rst_n) begin : receiver
        alloc_word_t want;
        int          draw;
        if (!rst_n) begin
            rsp_ready <= 1'b0;
            rx_wait   <= 0;
        end
        else if (rsp_valid && rsp_ready) begin
            words_seen++;
            if (result_expect.size() == 0) begin
                $error("unexpected result word: block_id=%0d byte_offset=%0d",
                       block_id, byte_offset);
                error_count++;
            end
            else begin
                want = result_expect.pop_front();
                if (want.pool_full)
                    full_count++;
                else if (want.made_new)
                    new_count++;
                else
                    fit_count++;
                if (block_id !== want.block_id) begin
                    $error("block_id: expected %0d, got %0d", want.block_id, block_id);
                    error_count++;
                end
                if (byte_offset !== want.byte_offset) begin
                    $error("byte_offset: expected %0d, got %0d",
                           want.byte_offset, byte_offset);
                    error_count++;
                end
                if (made_new_block !== want.made_new) begin
                    $error("made_new_block: expected %0d, got %0d",
                           want.made_new, made_new_block);
                    error_count++;
                end
                if (new_block_bytes !== want.new_bytes) begin
                    $error("new_block_bytes: expected %0d, got %0d",
                           want.new_bytes, new_block_bytes);
                    error_count++;
                end
                if (pool_full !== want.pool_full) begin
                    $error("pool_full: expected %0d, got %0d", want.pool_full, pool_full);
                    error_count++;
                end
            end
            if (words_seen == HOLD_AT_WORD)
                draw = LONG_HOLD;
            else if ((words_seen >= 200 && words_seen < 350) ||
                     (words_seen >= 1100 && words_seen < 1200))
                draw = 0;
            else
                draw = $urandom_range(0, 8);
            rx_wait   <= draw;
            rsp_ready <= (draw == 0);
        end
        else if (rx_wait > 0) begin
            rx_wait   <= rx_wait - 1;
            rsp_ready <= (rx_wait == 1);
        end
        else begin
            rsp_ready <= 1'b1;
        end
    end

    int idle_cycles = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_req(logic [SIZE_BITS-1:0] sz, logic [ALIGN_BITS-1:0] al);
        alloc_req_t r;
        r.size  = sz;
        r.align = al;
        pending_reqs.push_back(r);
    endtask

    initial begin : stimulus
        int                    pick;
        logic [SIZE_BITS-1:0]  sz;
        logic [ALIGN_BITS-1:0] al;

        // The first word decides the first block: below the minimum, at it,
        // or rounded up to the granule.
        case ($urandom_range(0, 3))
            0: push_req(24'd0, 13'd0);
            1: push_req(24'd255, 13'd0);
            2: push_req(24'd256, 13'd8);
            default: push_req(24'($urandom_range(257, 20000)), 13'd0);
        endcase
        push_req(24'd0, 13'd0);
        push_req(24'd1, 13'd1);
        push_req(24'd3, 13'd3);
        push_req(24'd16, 13'd16);
        push_req(24'd5, 13'd4095);
        // An aligned offset past the end, even for zero bytes.
        push_req(24'd0, 13'd4096);
        push_req(24'hFFFFFF, 13'd0);
        push_req(24'd4096, 13'd4096);
        push_req(24'd4097, 13'd2);
        push_req(24'd100, 13'd2048);
        push_req(24'd5000, 13'd7);
        push_req(24'd1, 13'd4096);
        push_req(24'd4095, 13'd0);
        push_req(24'd0, 13'd1);
        push_req(24'h800000, 13'd64);
        push_req(24'd12, 13'd5);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                sz = '0;
            else if (pick < 75)
                sz = 24'($urandom_range(0, 64));
            else if (pick < 87)
                sz = 24'($urandom_range(65, 1024));
            else if (pick < 94)
                sz = 24'($urandom_range(1025, 4095));
            else
                sz = 24'($urandom_range(4096, 24'hFFFFFF));
            pick = $urandom_range(0, 99);
            if (pick < 40)
                al = '0;
            else if (pick < 85)
                al = 13'(1 << $urandom_range(0, 6));
            else if (pick < 93)
                al = 13'(1 << $urandom_range(7, 12));
            else
                al = 13'($urandom_range(0, 4096));
            push_req(sz, al);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_valid || result_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d requests answered: %0d placed in a block, %0d new blocks, %0d full",
                 words_seen, fit_count, new_count, full_count);
        $display("tb: heap ended with %0d blocks, %0d mismatches", heap_count, error_count);
        if (error_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
